@@ design/spk_pkg.sv @@
package spk_pkg;

  // Width of every dimension held in the shelf state.
  localparam int unsigned DimW = 12;

  // Largest usable sheet side; the configured width and height are capped at it.
  localparam logic [DimW:0] MAX_DIM = 13'd2048;

  // Largest reported sheet height.
  localparam logic [DimW-1:0] SheetHMax = 12'd2048;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PACK_MODE    = 2'd0;
  localparam logic [1:0] CFG_SHEET_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT_LIMIT = 2'd2;

  // Rectangle kinds.
  localparam logic [1:0] KIND_FULL   = 2'd0;
  localparam logic [1:0] KIND_COLOUR = 2'd1;
  localparam logic [1:0] KIND_ALPHA  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_PLACED   = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_BAD_KIND = 2'd2;

  // Round a dimension up to the next power of two; zero rounds to one.
  function automatic logic [DimW:0] round_pow2(input logic [DimW-1:0] v);
    logic [DimW-1:0] x;
    x = v - 12'd1;
    x = x | (x >> 1);
    x = x | (x >> 2);
    x = x | (x >> 4);
    x = x | (x >> 8);
    if (v == '0) begin
      return 13'd1;
    end
    return {1'b0, x} + 13'd1;
  endfunction

endpackage

@@ design/shelf_rectangle_packer.sv @@
// Shelf next-fit rectangle packer.
// Input channel (in_valid_i / in_ready_o) carries one rectangle per item:
// width, height, kind and a last-item flag. Output channel (out_valid_o /
// out_ready_i) returns one result item per rectangle: placement column and
// line, status, and on the last item the sheet size rounded to powers of two.
// Each item is placed in the cycle it is accepted and its result is shown
// from the next cycle on, and one item can be accepted every cycle while
// the receiver takes results. The per-item shelf update (one add and compare
// per axis plus the power-of-two round-up) is combinational.
// A result register sits between the channels: while the receiver stalls a
// finished result is held, and a new item is taken in the same cycle that
// the held result is taken.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i while
// the block is idle, which binds the user; the block does not enforce it.
// Reset (rst_ni low) returns the registers to flat mode, width 2048 and
// height limit 2048 and clears both shelf planes, as does a pass's last item.
module shelf_rectangle_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [11:0] rect_width_i,
  input  logic [11:0] rect_height_i,
  input  logic [1:0]  rect_kind_i,
  input  logic        last_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [10:0] place_x_o,
  output logic [10:0] place_y_o,
  output logic [1:0]  status_o,
  output logic [12:0] sheet_w_o,
  output logic [11:0] sheet_h_o,
  output logic        is_last_o
);

  localparam int unsigned DW = spk_pkg::DimW;

  // Configuration registers.
  logic          pack_mode_q;
  logic [DW-1:0] sheet_width_q;
  logic [DW-1:0] height_limit_q;

  // Shelf state, one entry per plane.
  logic [1:0][DW-1:0] col_q, col_d;
  logic [1:0][DW-1:0] line_q, line_d;
  logic [1:0][DW-1:0] nl_q, nl_d;
  logic [1:0][DW-1:0] wid_q, wid_d;
  logic               full_phase_q, full_phase_d;
  logic [1:0]         failed_q, failed_d;

  // Result register.
  logic          out_valid_q;
  logic [10:0]   px_q, px_d;
  logic [10:0]   py_q, py_d;
  logic [1:0]    status_q;
  logic [DW:0]   sw_q, sw_d;
  logic [DW-1:0] sh_q, sh_d;
  logic          last_q;

  logic          accept;
  logic [DW-1:0] lim_w, lim_h;
  logic          plane, mirror;
  logic [1:0]    fail_a;
  logic [DW-1:0] col_s, line_s, nl_s, wid_s;
  logic          wrap, no_fit, place;
  logic [DW-1:0] col_a, line_a;
  logic [DW:0]   end_x, end_y;
  logic [DW-1:0] col_new, nl_new, wid_new;
  logic [DW-1:0] mw, mh;
  logic [DW:0]   sh_round;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Usable limits, capped at the largest sheet side.
  assign lim_w = ({1'b0, sheet_width_q} < spk_pkg::MAX_DIM) ? sheet_width_q
                                                            : spk_pkg::MAX_DIM[DW-1:0];
  assign lim_h = ({1'b0, height_limit_q} < spk_pkg::MAX_DIM) ? height_limit_q
                                                             : spk_pkg::MAX_DIM[DW-1:0];

  // Plane choice and kind checks.
  always_comb begin
    fail_a       = failed_q;
    plane        = 1'b0;
    mirror       = 1'b0;
    full_phase_d = full_phase_q;
    if (failed_q == spk_pkg::ST_PLACED && pack_mode_q) begin
      case (rect_kind_i)
        spk_pkg::KIND_COLOUR: begin
          full_phase_d = 1'b0;
        end
        spk_pkg::KIND_ALPHA: begin
          plane        = 1'b1;
          full_phase_d = 1'b0;
        end
        spk_pkg::KIND_FULL: begin
          if (full_phase_q) begin
            mirror = 1'b1;
          end else begin
            fail_a = spk_pkg::ST_BAD_KIND;
          end
        end
        default: begin
          fail_a = spk_pkg::ST_BAD_KIND;
        end
      endcase
    end
  end

  // Shelf fit test on the selected plane.
  always_comb begin
    col_s  = plane ? col_q[1]  : col_q[0];
    line_s = plane ? line_q[1] : line_q[0];
    nl_s   = plane ? nl_q[1]   : nl_q[0];
    wid_s  = plane ? wid_q[1]  : wid_q[0];
    wrap   = ({1'b0, col_s} + {1'b0, rect_width_i}) > {1'b0, lim_w};
    col_a  = wrap ? '0 : col_s;
    line_a = wrap ? nl_s : line_s;
    end_x  = {1'b0, col_a} + {1'b0, rect_width_i};
    end_y  = {1'b0, line_a} + {1'b0, rect_height_i};
    no_fit = (end_x > {1'b0, lim_w}) || (end_y > {1'b0, lim_h});
    place  = (fail_a == spk_pkg::ST_PLACED) && !no_fit;
    failed_d = (fail_a == spk_pkg::ST_PLACED && no_fit) ? spk_pkg::ST_NO_FIT : fail_a;
    col_new = end_x[DW-1:0];
    nl_new  = (end_y[DW-1:0] > nl_s) ? end_y[DW-1:0] : nl_s;
    wid_new = (col_new > wid_s) ? col_new : wid_s;
  end

  // Next shelf state, with mirroring of plane 0 during the full phase.
  always_comb begin
    col_d  = col_q;
    line_d = line_q;
    nl_d   = nl_q;
    wid_d  = wid_q;
    if (place) begin
      col_d[plane]  = col_new;
      line_d[plane] = line_a;
      nl_d[plane]   = nl_new;
      wid_d[plane]  = wid_new;
      if (mirror) begin
        col_d[1]  = col_new;
        line_d[1] = line_a;
        nl_d[1]   = nl_new;
        wid_d[1]  = wid_new;
      end
    end
  end

  // Result fields, including the sheet size on the last item.
  always_comb begin
    mw       = (wid_d[0] > wid_d[1]) ? wid_d[0] : wid_d[1];
    mh       = (nl_d[0] > nl_d[1]) ? nl_d[0] : nl_d[1];
    sh_round = spk_pkg::round_pow2(mh);
    px_d     = place ? col_a[10:0] : '0;
    py_d     = place ? line_a[10:0] : '0;
    sw_d     = '0;
    sh_d     = '0;
    if (last_item_i && failed_d == spk_pkg::ST_PLACED) begin
      sw_d = spk_pkg::round_pow2(mw);
      sh_d = (sh_round > {1'b0, spk_pkg::SheetHMax}) ? spk_pkg::SheetHMax
                                                     : sh_round[DW-1:0];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_mode_q    <= 1'b0;
      sheet_width_q  <= 12'd2048;
      height_limit_q <= 12'd2048;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spk_pkg::CFG_PACK_MODE:    pack_mode_q    <= cfg_data_i[0];
        spk_pkg::CFG_SHEET_WIDTH:  sheet_width_q  <= cfg_data_i;
        spk_pkg::CFG_HEIGHT_LIMIT: height_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shelf state; the last item of a pass clears it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      line_q       <= '0;
      nl_q         <= '0;
      wid_q        <= '0;
      full_phase_q <= 1'b1;
      failed_q     <= spk_pkg::ST_PLACED;
    end else if (accept) begin
      if (last_item_i) begin
        col_q        <= '0;
        line_q       <= '0;
        nl_q         <= '0;
        wid_q        <= '0;
        full_phase_q <= 1'b1;
        failed_q     <= spk_pkg::ST_PLACED;
      end else begin
        col_q        <= col_d;
        line_q       <= line_d;
        nl_q         <= nl_d;
        wid_q        <= wid_d;
        full_phase_q <= full_phase_d;
        failed_q     <= failed_d;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q     <= px_d;
      py_q     <= py_d;
      status_q <= failed_d;
      sw_q     <= sw_d;
      sh_q     <= sh_d;
      last_q   <= last_item_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign place_x_o   = px_q;
  assign place_y_o   = py_q;
  assign status_o    = status_q;
  assign sheet_w_o   = sw_q;
  assign sheet_h_o   = sh_q;
  assign is_last_o   = last_q;

`ifndef SYNTH
  // A stalled result is never dropped.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A rectangle that was not placed reports no position.
  a_fail_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != spk_pkg::ST_PLACED |-> place_x_o == '0 && place_y_o == '0)
    else $error("position given for a rectangle that was not placed");

  // A successful pass reports power-of-two sheet sides.
  a_pow2_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_last_o && status_o == spk_pkg::ST_PLACED
      |-> $onehot(sheet_w_o) && $onehot(sheet_h_o))
    else $error("sheet size is not a power of two");

  // Sheet size is zero unless this is the last item of a successful pass.
  a_size_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (!is_last_o || status_o != spk_pkg::ST_PLACED)
      |-> sheet_w_o == '0 && sheet_h_o == '0)
    else $error("sheet size reported outside a successful last item");
`endif

endmodule

@@ tb/shelf_rectangle_packer_checker.sv @@
`timescale 1ns / 1ps

module shelf_rectangle_packer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [11:0] rect_width_i,
  input  logic [11:0] rect_height_i,
  input  logic [1:0]  rect_kind_i,
  input  logic        last_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [10:0] place_x_i,
  input  logic [10:0] place_y_i,
  input  logic [1:0]  status_i,
  input  logic [12:0] sheet_w_i,
  input  logic [11:0] sheet_h_i,
  input  logic        is_last_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // One result item as the block reports it.
  typedef struct packed {
    logic [10:0] place_x;
    logic [10:0] place_y;
    logic [1:0]  status;
    logic [12:0] sheet_w;
    logic [11:0] sheet_h;
    logic        is_last;
  } placement_t;

  placement_t placements_due[$];
  int unsigned mismatches;

  // Shadow copy of the registers.
  logic        split_mode;
  logic [11:0] width_reg;
  logic [11:0] height_reg;

  // Shadow copy of the two shelf planes and the pass flags.
  logic [11:0] column_q    [2];
  logic [11:0] line_q      [2];
  logic [11:0] next_line_q [2];
  logic [11:0] widest_q    [2];
  logic        full_phase_q;
  logic [1:0]  sticky_status_q;

  assign fail_count_o = mismatches;

  // Smallest power of two not below v, with zero giving one.
  function automatic logic [12:0] pow2_ceil(input logic [11:0] v);
    logic [12:0] r;
    r = 13'd1;
    while (r < {1'b0, v}) r = r << 1;
    return r;
  endfunction

  task automatic clear_shelves();
    for (int p = 0; p < 2; p++) begin
      column_q[p]    = '0;
      line_q[p]      = '0;
      next_line_q[p] = '0;
      widest_q[p]    = '0;
    end
    full_phase_q    = 1'b1;
    sticky_status_q = spk_pkg::ST_PLACED;
  endtask

  // Place one rectangle on its plane and work out the result item it gives.
  task automatic place_rect(input logic [11:0] w, input logic [11:0] h,
                            input logic [1:0] kind, input logic last,
                            output placement_t res);
    logic [11:0] lim_w;
    logic [11:0] lim_h;
    logic [13:0] right_edge;
    logic [13:0] bottom_edge;
    logic [11:0] wide;
    logic [11:0] low;
    logic [12:0] rounded_h;
    int          plane;
    bit          mirror;

    res    = '0;
    lim_w  = (width_reg > spk_pkg::MAX_DIM) ? spk_pkg::MAX_DIM[11:0] : width_reg;
    lim_h  = (height_reg > spk_pkg::MAX_DIM) ? spk_pkg::MAX_DIM[11:0] : height_reg;
    plane  = 0;
    mirror = 1'b0;

    // In split mode the kind picks the plane; full items are only legal first.
    if (sticky_status_q == spk_pkg::ST_PLACED && split_mode) begin
      if (kind == spk_pkg::KIND_COLOUR || kind == spk_pkg::KIND_ALPHA) begin
        plane = (kind == spk_pkg::KIND_ALPHA) ? 1 : 0;
        full_phase_q = 1'b0;
      end else if (kind == spk_pkg::KIND_FULL) begin
        if (full_phase_q) mirror = 1'b1;
        else sticky_status_q = spk_pkg::ST_BAD_KIND;
      end else begin
        sticky_status_q = spk_pkg::ST_BAD_KIND;
      end
    end

    if (sticky_status_q == spk_pkg::ST_PLACED) begin
      // Overflowing the width closes the shelf.
      if ({2'b00, column_q[plane]} + {2'b00, w} > {2'b00, lim_w}) begin
        column_q[plane] = '0;
        line_q[plane]   = next_line_q[plane];
      end
      right_edge  = {2'b00, column_q[plane]} + {2'b00, w};
      bottom_edge = {2'b00, line_q[plane]} + {2'b00, h};
      if (right_edge > {2'b00, lim_w} || bottom_edge > {2'b00, lim_h}) begin
        sticky_status_q = spk_pkg::ST_NO_FIT;
      end else begin
        res.place_x = column_q[plane][10:0];
        res.place_y = line_q[plane][10:0];
        if (bottom_edge[11:0] > next_line_q[plane]) next_line_q[plane] = bottom_edge[11:0];
        column_q[plane] = right_edge[11:0];
        if (column_q[plane] > widest_q[plane]) widest_q[plane] = column_q[plane];
        if (mirror) begin
          column_q[1]    = column_q[0];
          line_q[1]      = line_q[0];
          next_line_q[1] = next_line_q[0];
          widest_q[1]    = widest_q[0];
        end
      end
    end

    res.status  = sticky_status_q;
    res.is_last = last;

    // The last item of a clean pass reports the rounded sheet size.
    if (last && sticky_status_q == spk_pkg::ST_PLACED) begin
      wide = (widest_q[0] > widest_q[1]) ? widest_q[0] : widest_q[1];
      low  = (next_line_q[0] > next_line_q[1]) ? next_line_q[0] : next_line_q[1];
      res.sheet_w = pow2_ceil(wide);
      rounded_h   = pow2_ceil(low);
      res.sheet_h = (rounded_h > {1'b0, spk_pkg::SheetHMax}) ? spk_pkg::SheetHMax
                                                             : rounded_h[11:0];
    end

    if (last) clear_shelves();
  endtask

  // Watch both channels and the register port at every edge.
  always @(posedge clk_i or negedge rst_ni) begin
    placement_t got;
    placement_t want;
    placement_t fresh;
    if (!rst_ni) begin
      split_mode = 1'b0;
      width_reg  = 12'd2048;
      height_reg = 12'd2048;
      clear_shelves();
      placements_due.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      // A result item leaving now was predicted at an earlier edge.
      if (out_valid_i && out_ready_i) begin
        got = {place_x_i, place_y_i, status_i, sheet_w_i, sheet_h_i, is_last_i};
        if (placements_due.size() == 0) begin
          mismatches++;
          $display("%0t: result item with none expected: x=%0d y=%0d status=%0d",
                   $time, place_x_i, place_y_i, status_i);
        end else begin
          want = placements_due.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: expected x=%0d y=%0d status=%0d sheet=%0dx%0d last=%0d",
                     $time, want.place_x, want.place_y, want.status,
                     want.sheet_w, want.sheet_h, want.is_last);
            $display("%0t: actual   x=%0d y=%0d status=%0d sheet=%0dx%0d last=%0d",
                     $time, got.place_x, got.place_y, got.status,
                     got.sheet_w, got.sheet_h, got.is_last);
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          spk_pkg::CFG_PACK_MODE:    split_mode = cfg_data_i[0];
          spk_pkg::CFG_SHEET_WIDTH:  width_reg  = cfg_data_i;
          spk_pkg::CFG_HEIGHT_LIMIT: height_reg = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        place_rect(rect_width_i, rect_height_i, rect_kind_i, last_item_i, fresh);
        placements_due.push_back(fresh);
      end

      pending_o <= placements_due.size();
    end
  end

endmodule

@@ tb/tb_shelf_rectangle_packer.sv @@
`timescale 1ns / 1ps

module tb_shelf_rectangle_packer;

  localparam int RandomItems = 410;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = spk_pkg::CFG_PACK_MODE;
  logic [11:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] rect_width = '0;
  logic [11:0] rect_height = '0;
  logic [1:0]  rect_kind = spk_pkg::KIND_FULL;
  logic        last_item = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [10:0] place_x;
  logic [10:0] place_y;
  logic [1:0]  status;
  logic [12:0] sheet_w;
  logic [11:0] sheet_h;
  logic        is_last;

  int unsigned fail_count;
  int unsigned pending;

  // Stimulus bookkeeping.
  int          items_sent = 0;
  int          passes_sent = 0;
  int          settings_used = 0;
  int          rx_stall = 0;
  bit          calm_tx = 1'b0;
  bit          calm_rx = 1'b0;
  logic        cur_split = 1'b0;
  logic [11:0] cur_width = 12'd2048;
  logic [11:0] cur_height = 12'd2048;

  always #10 clk_i = ~clk_i;

  shelf_rectangle_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .rect_width_i  (rect_width),
    .rect_height_i (rect_height),
    .rect_kind_i   (rect_kind),
    .last_item_i   (last_item),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .place_x_o     (place_x),
    .place_y_o     (place_y),
    .status_o      (status),
    .sheet_w_o     (sheet_w),
    .sheet_h_o     (sheet_h),
    .is_last_o     (is_last)
  );

  shelf_rectangle_packer_checker checker_u (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .rect_width_i  (rect_width),
    .rect_height_i (rect_height),
    .rect_kind_i   (rect_kind),
    .last_item_i   (last_item),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .place_x_i     (place_x),
    .place_y_i     (place_y),
    .status_i      (status),
    .sheet_w_i     (sheet_w),
    .sheet_h_i     (sheet_h),
    .is_last_i     (is_last),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Idle spans: mostly none or short, now and then long.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Rectangle side: mostly small against the limit, sometimes exact, zero or wild.
  function automatic logic [11:0] pick_side(input logic [11:0] limit);
    int unsigned lim;
    int          r;
    lim = (limit > spk_pkg::MAX_DIM) ? 32'(spk_pkg::MAX_DIM) : 32'(limit);
    if (lim == 0) lim = 1;
    r = $urandom_range(0, 19);
    if (r == 0) return 12'd0;
    if (r == 1) return 12'($urandom_range(0, 4095));
    if (r == 2) return 12'(lim);
    return 12'($urandom_range(1, (lim > 6) ? lim / 6 : 1));
  endfunction

  // Register setting: the extremes, the full field, small and large sizes.
  function automatic logic [11:0] pick_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 12'd1;
    if (r == 1) return 12'd2048;
    if (r == 2) return 12'($urandom_range(0, 4095));
    if (r < 6) return 12'($urandom_range(16, 128));
    return 12'($urandom_range(129, 2048));
  endfunction

  // Receiver side: ready drops for random spans unless in a calm stretch.
  always @(posedge clk_i) begin
    if (rx_stall == 0 && !calm_rx && $urandom_range(0, 3) == 0) rx_stall = idle_span();
    if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one rectangle item and hold it until it is accepted.
  task automatic send_rect(input logic [11:0] w, input logic [11:0] h,
                           input logic [1:0] kind, input logic last);
    int idle;
    idle = calm_tx ? 0 : idle_span();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    rect_width  <= w;
    rect_height <= h;
    rect_kind   <= kind;
    last_item   <= last;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
    if (last) passes_sent++;
  endtask

  // Stop sending until every predicted result item has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // Write all three registers while the block is idle.
  task automatic apply_cfg(input logic split, input logic [11:0] w, input logic [11:0] h);
    logic [10:0] junk;
    junk = 11'($urandom_range(0, 2047));
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= spk_pkg::CFG_PACK_MODE;
    cfg_data  <= {junk, split};
    @(posedge clk_i);
    cfg_index <= spk_pkg::CFG_SHEET_WIDTH;
    cfg_data  <= w;
    @(posedge clk_i);
    cfg_index <= spk_pkg::CFG_HEIGHT_LIMIT;
    cfg_data  <= h;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    cur_split  = split;
    cur_width  = w;
    cur_height = h;
    settings_used++;
  endtask

  // One packing pass; in split mode mostly well ordered, sometimes scrambled.
  task automatic run_pass();
    int         n;
    int         fulls;
    bit         noisy;
    logic [1:0] kind;
    n     = $urandom_range(1, 12);
    fulls = $urandom_range(0, 2);
    noisy = ($urandom_range(0, 7) == 0);
    for (int k = 0; k < n; k++) begin
      if (!cur_split || noisy) kind = 2'($urandom_range(0, 3));
      else if (k < fulls) kind = spk_pkg::KIND_FULL;
      else kind = 2'($urandom_range(32'(spk_pkg::KIND_COLOUR), 32'(spk_pkg::KIND_ALPHA)));
      if ((k > 0 && k == n / 2 && passes_sent % 5 == 0) || $urandom_range(0, 39) == 0)
        drain();
      send_rect(pick_side(cur_width), pick_side(cur_height), kind, k == n - 1);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Flat mode at reset values: a sheet-filling item, exact fit, new shelf.
    send_rect(12'd2048, 12'd2048, spk_pkg::KIND_FULL, 1'b1);
    send_rect(12'd1, 12'd1, 2'd3, 1'b0);
    send_rect(12'd2047, 12'd1, spk_pkg::KIND_COLOUR, 1'b0);
    send_rect(12'd1, 12'd1, spk_pkg::KIND_ALPHA, 1'b1);
    // Zero sizes, then width and height overflow with the sticky failure.
    send_rect(12'd0, 12'd0, spk_pkg::KIND_FULL, 1'b1);
    send_rect(12'd4095, 12'd1, spk_pkg::KIND_FULL, 1'b0);
    send_rect(12'd8, 12'd8, spk_pkg::KIND_FULL, 1'b0);
    send_rect(12'd0, 12'd0, spk_pkg::KIND_FULL, 1'b1);
    send_rect(12'd100, 12'd2049, spk_pkg::KIND_FULL, 1'b1);

    // Split mode, one pixel wide: full items mirror into the alpha plane.
    apply_cfg(1'b1, 12'd1, 12'd2048);
    send_rect(12'd1, 12'd3, spk_pkg::KIND_FULL, 1'b0);
    send_rect(12'd1, 12'd2, spk_pkg::KIND_COLOUR, 1'b0);
    send_rect(12'd1, 12'd5, spk_pkg::KIND_ALPHA, 1'b0);
    send_rect(12'd0, 12'd4, spk_pkg::KIND_COLOUR, 1'b1);
    // A full item after split ones, then an unknown kind.
    send_rect(12'd1, 12'd1, spk_pkg::KIND_COLOUR, 1'b0);
    send_rect(12'd1, 12'd1, spk_pkg::KIND_FULL, 1'b0);
    send_rect(12'd1, 12'd1, spk_pkg::KIND_ALPHA, 1'b1);
    send_rect(12'd1, 12'd1, spk_pkg::KIND_FULL, 1'b0);
    send_rect(12'd1, 12'd1, 2'd3, 1'b1);

    // Over-range registers cap at the largest side; height limit of one.
    apply_cfg(1'b1, 12'd4095, 12'd1);
    send_rect(12'd2048, 12'd1, spk_pkg::KIND_ALPHA, 1'b0);
    send_rect(12'd4095, 12'd1, spk_pkg::KIND_COLOUR, 1'b0);
    send_rect(12'd1, 12'd1, spk_pkg::KIND_FULL, 1'b1);
    apply_cfg(1'b0, 12'd2048, 12'd4095);
    send_rect(12'd1, 12'd2048, 2'd3, 1'b0);
    send_rect(12'd2047, 12'd2048, spk_pkg::KIND_FULL, 1'b1);

    // Random phases, each with fresh registers and a few passes.
    begin
      int target;
      target = items_sent + RandomItems;
      while (items_sent < target) begin
        calm_tx = ($urandom_range(0, 4) == 0);
        calm_rx = ($urandom_range(0, 4) == 0);
        apply_cfg(1'($urandom_range(0, 1)), pick_dim(), pick_dim());
        repeat ($urandom_range(2, 6)) run_pass();
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d rectangles in %0d passes under %0d register settings,",
             items_sent, passes_sent, settings_used);
    $display("flat and split, with stalls on both channels.");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #(10_000_000);
    $display("status: fail");
    $finish;
  end

endmodule
